// ===== rtl/core/dcc_pkg.sv =====
// Shared types, register map codes and helpers for the DMA channel controller.
// Used by dcc_ctrl, dcc_datapath and the top level dma_channel_controller.
package dcc_pkg;

    // Default configuration of the top level.
    localparam int DEF_CHANNEL_COUNT = 4;
    localparam int DEF_REQUEST_LINES = 16;

    // Item operation codes.
    localparam logic [2:0] OP_READ16  = 3'd0;
    localparam logic [2:0] OP_WRITE16 = 3'd1;
    localparam logic [2:0] OP_WRITE32 = 3'd2;
    localparam logic [2:0] OP_SET_REQ = 3'd3;
    localparam logic [2:0] OP_CLR_REQ = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    // Register map.
    localparam logic [5:0] OFFS_MASTER = 6'h08;
    localparam logic [3:0] REG_SRC     = 4'h0;
    localparam logic [3:0] REG_DST     = 4'h4;
    localparam logic [3:0] REG_COUNT   = 4'hA;
    localparam logic [3:0] REG_CTRL    = 4'hE;

    // A count write of zero loads a full 64K transfer.
    localparam logic [16:0] COUNT_FULL = 17'h10000;

    // Control word bit positions and step codes.
    localparam int CTRL_EN   = 0;
    localparam int CTRL_FIN  = 1;
    localparam int CTRL_WIDE = 3;
    localparam logic [1:0] STEP_INC = 2'd1;
    localparam logic [1:0] STEP_DEC = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic activate;
    } dcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_activate;
        logic out_blocked;
    } dcc_status_t;

    // Address step for one beat; wide moves step by two.
    function automatic logic [31:0] step_of(input logic [1:0] code, input logic wide);
        logic [31:0] s;
        begin
            s = 32'd0;
            if (code == STEP_INC)
            begin
                s = wide ? 32'd2 : 32'd1;
            end
            else if (code == STEP_DEC)
            begin
                s = wide ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
            end
            return s;
        end
    endfunction

endpackage

// ===== rtl/core/dcc_ctrl.sv =====
// Sequencer of the DMA channel controller: accepts an item, executes it and,
// for control writes and request sets, runs the activation check. Uses dcc_pkg.
module dcc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dcc_pkg::dcc_status_t status,
    output dcc_pkg::dcc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_ACT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.activate = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!status.out_blocked)
                begin
                    cmd.execute = 1'b1;
                    state_next  = status.needs_activate ? ST_ACT : ST_IDLE;
                end
            end
            ST_ACT:
            begin
                cmd.activate = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The input side is open only between items.
    assign in_stall = (state_reg != ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted item enters the execution state next.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXEC)
        else $error("accepted item did not enter execution");

    // Control writes and request sets are followed by the activation check.
    a_exec_to_act: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && status.needs_activate |=> cmd.activate)
        else $error("activation check skipped");

    // Nothing executes while the output register is still held.
    a_no_exec_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !status.out_blocked)
        else $error("execution while result is stalled");

endmodule

// ===== rtl/core/dcc_datapath.sv =====
// Datapath of the DMA channel controller: item register, channel register
// file, request flags, beat logic and result register. Uses dcc_pkg.
module dcc_datapath
#(
    parameter int CHANNEL_COUNT = dcc_pkg::DEF_CHANNEL_COUNT,
    parameter int REQUEST_LINES = dcc_pkg::DEF_REQUEST_LINES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dcc_pkg::dcc_cmd_t    cmd,
    output dcc_pkg::dcc_status_t status,
    input  logic [2:0]           operation,
    input  logic [5:0]           reg_offset,
    input  logic [31:0]          write_data,
    input  logic [3:0]           request_line,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          read_data,
    output logic                 move_valid,
    output logic [31:0]          move_source,
    output logic [31:0]          move_dest,
    output logic                 move_wide,
    output logic [1:0]           move_channel,
    output logic                 channel_done
);

    // Captured item.
    logic [2:0]  op_reg;
    logic [5:0]  off_reg;
    logic [31:0] data_reg;
    logic [3:0]  line_reg;

    // Channel register file and global state.
    logic [31:0] src_reg  [CHANNEL_COUNT];
    logic [31:0] src_next [CHANNEL_COUNT];
    logic [31:0] dst_reg  [CHANNEL_COUNT];
    logic [31:0] dst_next [CHANNEL_COUNT];
    logic [16:0] cnt_reg  [CHANNEL_COUNT];
    logic [16:0] cnt_next [CHANNEL_COUNT];
    logic [15:0] ctrl_reg [CHANNEL_COUNT];
    logic [15:0] ctrl_next[CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] run_reg;
    logic [CHANNEL_COUNT-1:0] run_next;
    logic [REQUEST_LINES-1:0] flags_reg;
    logic [REQUEST_LINES-1:0] flags_next;
    logic [15:0] master_reg;
    logic [15:0] master_next;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] read_data_reg;
    logic [15:0] read_data_next;
    logic        move_valid_reg;
    logic        move_valid_next;
    logic [31:0] move_source_reg;
    logic [31:0] move_source_next;
    logic [31:0] move_dest_reg;
    logic [31:0] move_dest_next;
    logic        move_wide_reg;
    logic        move_wide_next;
    logic [1:0]  move_channel_reg;
    logic [1:0]  move_channel_next;
    logic        channel_done_reg;
    logic        channel_done_next;

    // Finished and running at once, watched by an assertion.
    logic [CHANNEL_COUNT-1:0] run_and_fin;

    logic [1:0] ch;
    logic [3:0] reg_sel;

    // A request line reads as set only if it exists and its flag is set.
    function automatic logic line_set(input logic [3:0] sel,
                                      input logic [REQUEST_LINES-1:0] flags);
        logic hit;
        begin
            hit = 1'b0;
            for (int l = 0; l < REQUEST_LINES; l++)
            begin
                if (sel == 4'(l))
                begin
                    hit = flags[l];
                end
            end
            return hit;
        end
    endfunction

    assign ch      = off_reg[5:4];
    assign reg_sel = off_reg[3:0];

    // Status for the sequencer.
    assign status.needs_activate = (op_reg == dcc_pkg::OP_SET_REQ) ||
        ((op_reg == dcc_pkg::OP_WRITE16) && (reg_sel == dcc_pkg::REG_CTRL) &&
         (off_reg != dcc_pkg::OFFS_MASTER) && ({30'd0, ch} < 32'(CHANNEL_COUNT)));
    assign status.out_blocked = out_valid_reg && out_stall;

    // Item execution, beat selection and the activation check.
    always_comb
    begin
        logic [15:0] v;
        logic [15:0] w;
        logic        found;
        logic        wide;
        logic [16:0] cnt_dec;

        src_next    = src_reg;
        dst_next    = dst_reg;
        cnt_next    = cnt_reg;
        ctrl_next   = ctrl_reg;
        run_next    = run_reg;
        flags_next  = flags_reg;
        master_next = master_reg;

        read_data_next    = '0;
        move_valid_next   = 1'b0;
        move_source_next  = '0;
        move_dest_next    = '0;
        move_wide_next    = 1'b0;
        move_channel_next = '0;
        channel_done_next = 1'b0;

        v       = data_reg[15:0];
        w       = '0;
        found   = 1'b0;
        wide    = 1'b0;
        cnt_dec = '0;

        if (cmd.execute)
        begin
            unique case (op_reg)
                dcc_pkg::OP_READ16:
                begin
                    if (off_reg == dcc_pkg::OFFS_MASTER)
                    begin
                        read_data_next = master_reg;
                    end
                    else
                    begin
                        for (int c = 0; c < CHANNEL_COUNT; c++)
                        begin
                            if (ch == 2'(c) && reg_sel == dcc_pkg::REG_COUNT)
                            begin
                                read_data_next = cnt_reg[c][15:0];
                            end
                            else if (ch == 2'(c) && reg_sel == dcc_pkg::REG_CTRL)
                            begin
                                read_data_next = ctrl_reg[c];
                            end
                        end
                    end
                end
                dcc_pkg::OP_WRITE16:
                begin
                    if (off_reg == dcc_pkg::OFFS_MASTER)
                    begin
                        master_next = v;
                    end
                    else
                    begin
                        for (int c = 0; c < CHANNEL_COUNT; c++)
                        begin
                            if (ch == 2'(c) && reg_sel == dcc_pkg::REG_COUNT)
                            begin
                                cnt_next[c] = (v != 16'd0) ? {1'b0, v} : dcc_pkg::COUNT_FULL;
                            end
                            else if (ch == 2'(c) && reg_sel == dcc_pkg::REG_CTRL)
                            begin
                                // Software can only clear the finished flag.
                                w = v;
                                w[dcc_pkg::CTRL_FIN] = ctrl_reg[c][dcc_pkg::CTRL_FIN] &
                                                       v[dcc_pkg::CTRL_FIN];
                                ctrl_next[c] = w;
                                if (!w[dcc_pkg::CTRL_EN] || w[dcc_pkg::CTRL_FIN])
                                begin
                                    run_next[c] = 1'b0;
                                end
                            end
                        end
                    end
                end
                dcc_pkg::OP_WRITE32:
                begin
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                    begin
                        if (ch == 2'(c) && reg_sel == dcc_pkg::REG_SRC)
                        begin
                            src_next[c] = data_reg;
                        end
                        else if (ch == 2'(c) && reg_sel == dcc_pkg::REG_DST)
                        begin
                            dst_next[c] = data_reg;
                        end
                    end
                end
                dcc_pkg::OP_SET_REQ:
                begin
                    for (int l = 0; l < REQUEST_LINES; l++)
                    begin
                        if (line_reg == 4'(l))
                        begin
                            flags_next[l] = 1'b1;
                        end
                    end
                end
                dcc_pkg::OP_CLR_REQ:
                begin
                    for (int l = 0; l < REQUEST_LINES; l++)
                    begin
                        if (line_reg == 4'(l))
                        begin
                            flags_next[l] = 1'b0;
                        end
                    end
                end
                dcc_pkg::OP_TICK:
                begin
                    // Channels whose request line dropped pause.
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                    begin
                        if (run_reg[c] && !line_set(ctrl_reg[c][11:8], flags_reg))
                        begin
                            run_next[c] = 1'b0;
                        end
                    end
                    // The lowest running channel moves one beat.
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                    begin
                        if (!found && run_next[c])
                        begin
                            found   = 1'b1;
                            wide    = ctrl_reg[c][dcc_pkg::CTRL_WIDE];
                            cnt_dec = cnt_reg[c] - 17'd1;
                            move_valid_next   = 1'b1;
                            move_source_next  = src_reg[c];
                            move_dest_next    = dst_reg[c];
                            move_wide_next    = wide;
                            move_channel_next = 2'(c);
                            src_next[c] = src_reg[c] +
                                dcc_pkg::step_of(ctrl_reg[c][13:12], wide);
                            dst_next[c] = dst_reg[c] +
                                dcc_pkg::step_of(ctrl_reg[c][15:14], wide);
                            cnt_next[c] = cnt_dec;
                            if (cnt_dec == 17'd0)
                            begin
                                ctrl_next[c][dcc_pkg::CTRL_FIN] = 1'b1;
                                run_next[c]       = 1'b0;
                                channel_done_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.activate && master_reg[0])
        begin
            // Start every enabled, unfinished, idle channel whose line is set; a zero count finishes it instead.
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                if (ctrl_reg[c][dcc_pkg::CTRL_EN] && !ctrl_reg[c][dcc_pkg::CTRL_FIN] &&
                    !run_reg[c] && line_set(ctrl_reg[c][11:8], flags_reg))
                begin
                    if (cnt_reg[c] == 17'd0)
                    begin
                        ctrl_next[c][dcc_pkg::CTRL_FIN] = 1'b1;
                    end
                    else
                    begin
                        run_next[c] = 1'b1;
                    end
                end
            end
        end
    end

    // Result register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Channel state, flags and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                src_reg[c]  <= '0;
                dst_reg[c]  <= '0;
                cnt_reg[c]  <= '0;
                ctrl_reg[c] <= '0;
            end
            run_reg       <= '0;
            flags_reg     <= {{(REQUEST_LINES-1){1'b0}}, 1'b1};
            master_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cnt_reg       <= cnt_next;
            ctrl_reg      <= ctrl_next;
            run_reg       <= run_next;
            flags_reg     <= flags_next;
            master_reg    <= master_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            off_reg  <= reg_offset;
            data_reg <= write_data;
            line_reg <= request_line;
        end
        if (cmd.execute)
        begin
            read_data_reg    <= read_data_next;
            move_valid_reg   <= move_valid_next;
            move_source_reg  <= move_source_next;
            move_dest_reg    <= move_dest_next;
            move_wide_reg    <= move_wide_next;
            move_channel_reg <= move_channel_next;
            channel_done_reg <= channel_done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign move_valid   = move_valid_reg;
    assign move_source  = move_source_reg;
    assign move_dest    = move_dest_reg;
    assign move_wide    = move_wide_reg;
    assign move_channel = move_channel_reg;
    assign channel_done = channel_done_reg;

    always_comb
    begin
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            run_and_fin[c] = run_reg[c] && ctrl_reg[c][dcc_pkg::CTRL_FIN];
        end
    end

    // A running channel is never marked finished.
    a_run_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
        run_and_fin == '0)
        else $error("channel running while finished");

    // A completed transfer is always reported with a beat.
    a_done_has_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && channel_done_reg |-> move_valid_reg)
        else $error("done without a move");

    // A result without a beat carries zero move fields.
    a_idle_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !move_valid_reg |-> move_source_reg == '0 &&
        move_dest_reg == '0 && !move_wide_reg && move_channel_reg == '0)
        else $error("move fields set without a beat");

endmodule

// ===== rtl/core/dma_channel_controller.sv =====
// Four-channel DMA controller: register access, request lines and one beat per tick.
// An accepted item is captured, then executed by the sequencer once the result register is
// not held, and its result is registered. Control writes and request sets add an activation
// check step; the sequencer in dcc_ctrl stalls the input until an item is through.
// Reset (rst_n, asynchronous, active low) clears all channel state, leaves only
// request line 0 set and empties the result register. Uses dcc_pkg, dcc_ctrl, dcc_datapath.
module dma_channel_controller
#(
    parameter int CHANNEL_COUNT = dcc_pkg::DEF_CHANNEL_COUNT,
    parameter int REQUEST_LINES = dcc_pkg::DEF_REQUEST_LINES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [5:0]  reg_offset,
    input  logic [31:0] write_data,
    input  logic [3:0]  request_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        move_valid,
    output logic [31:0] move_source,
    output logic [31:0] move_dest,
    output logic        move_wide,
    output logic [1:0]  move_channel,
    output logic        channel_done
);

    dcc_pkg::dcc_cmd_t    cmd;
    dcc_pkg::dcc_status_t status;

    // Sequencer.
    dcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Register file and beat datapath.
    dcc_datapath
    #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .REQUEST_LINES (REQUEST_LINES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .reg_offset   (reg_offset),
        .write_data   (write_data),
        .request_line (request_line),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .move_valid   (move_valid),
        .move_source  (move_source),
        .move_dest    (move_dest),
        .move_wide    (move_wide),
        .move_channel (move_channel),
        .channel_done (channel_done)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the four-channel DMA channel controller.
// Depends on dcc_pkg and dma_channel_controller; a built-in predictor of the register file
// and beat sequencing checks every result item in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH    = dcc_pkg::DEF_CHANNEL_COUNT;
    localparam int NUM_LINES = dcc_pkg::DEF_REQUEST_LINES;

    // Operation codes the block does not define; they must do nothing.
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // Step codes that mean "no step".
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_HOLD = 2'd3;

    // One result item as the block reports it.
    typedef struct packed {
        logic [15:0] read_data;
        logic        move_valid;
        logic [31:0] move_source;
        logic [31:0] move_dest;
        logic        move_wide;
        logic [1:0]  move_channel;
        logic        channel_done;
    } dma_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [5:0]  reg_offset;
    logic [31:0] write_data;
    logic [3:0]  request_line;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] read_data;
    logic        move_valid;
    logic [31:0] move_source;
    logic [31:0] move_dest;
    logic        move_wide;
    logic [1:0]  move_channel;
    logic        channel_done;

    // Predicted register file and channel state.
    logic [31:0] src_addr_q [NUM_CH];
    logic [31:0] dst_addr_q [NUM_CH];
    logic [16:0] count_q [NUM_CH];
    logic [15:0] ctrl_q [NUM_CH];
    bit          running_q [NUM_CH];
    bit          request_q [NUM_LINES];
    logic [15:0] master_q;

    dma_result_t pending_results[$];
    dma_result_t oldest_result;
    bit          gaps_on;
    int          items_sent;
    int          failures;

    dma_channel_controller #(
        .CHANNEL_COUNT(NUM_CH),
        .REQUEST_LINES(NUM_LINES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .reg_offset(reg_offset),
        .write_data(write_data),
        .request_line(request_line),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .move_valid(move_valid),
        .move_source(move_source),
        .move_dest(move_dest),
        .move_wide(move_wide),
        .move_channel(move_channel),
        .channel_done(channel_done)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state after reset: only the auto request line is set.
    function automatic void clear_channel_state();
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                src_addr_q[c] = '0;
                dst_addr_q[c] = '0;
                count_q[c]    = '0;
                ctrl_q[c]     = '0;
                running_q[c]  = 1'b0;
            end
            for (int l = 0; l < NUM_LINES; l++)
            begin
                request_q[l] = (l == 0);
            end
            master_q = '0;
        end
    endfunction

    // Lines beyond the implemented range never count as set.
    function automatic bit line_is_set(logic [3:0] line);
        begin
            if (line >= NUM_LINES)
            begin
                return 1'b0;
            end
            return request_q[line];
        end
    endfunction

    // Start every idle, enabled, unfinished channel whose request line is up.
    function automatic void start_ready_channels();
        logic [15:0] w;
        begin
            if (master_q[0])
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    w = ctrl_q[c];
                    if (w[dcc_pkg::CTRL_EN] && !w[dcc_pkg::CTRL_FIN] && !running_q[c] &&
                        line_is_set(w[11:8]))
                    begin
                        // A zero count finishes the channel without any beat.
                        if (count_q[c] == '0)
                        begin
                            ctrl_q[c][dcc_pkg::CTRL_FIN] = 1'b1;
                        end
                        else
                        begin
                            running_q[c] = 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    // Signed address increment for one beat, doubled for 16-bit moves.
    function automatic logic [31:0] beat_stride(logic [1:0] code, logic wide);
        logic [31:0] s;
        begin
            case (code)
                dcc_pkg::STEP_INC: s = 32'd1;
                dcc_pkg::STEP_DEC: s = '1;
                default:           s = '0;
            endcase
            return wide ? (s << 1) : s;
        end
    endfunction

    // Apply one accepted item to the predicted state and return its result item.
    function automatic dma_result_t apply_item(logic [2:0] op, logic [5:0] off,
                                               logic [31:0] data, logic [3:0] line);
        dma_result_t r;
        logic [1:0]  ch;
        logic [3:0]  rg;
        bit          ch_ok;
        bit          moved;
        logic [15:0] v;
        logic [15:0] w;
        begin
            r = '0;
            ch = off[5:4];
            rg = off[3:0];
            ch_ok = (ch < NUM_CH);
            moved = 1'b0;
            v = data[15:0];
            case (op)
                dcc_pkg::OP_READ16:
                begin
                    if (off == dcc_pkg::OFFS_MASTER)
                        r.read_data = master_q;
                    else if (ch_ok && rg == dcc_pkg::REG_COUNT)
                        r.read_data = count_q[ch][15:0];
                    else if (ch_ok && rg == dcc_pkg::REG_CTRL)
                        r.read_data = ctrl_q[ch];
                end
                dcc_pkg::OP_WRITE16:
                begin
                    if (off == dcc_pkg::OFFS_MASTER)
                    begin
                        master_q = v;
                    end
                    else if (ch_ok && rg == dcc_pkg::REG_COUNT)
                    begin
                        count_q[ch] = (v != '0) ? {1'b0, v} : dcc_pkg::COUNT_FULL;
                    end
                    else if (ch_ok && rg == dcc_pkg::REG_CTRL)
                    begin
                        // The finished flag can only be cleared by a write.
                        w = v;
                        w[dcc_pkg::CTRL_FIN] = ctrl_q[ch][dcc_pkg::CTRL_FIN] &
                                               v[dcc_pkg::CTRL_FIN];
                        ctrl_q[ch] = w;
                        if (!w[dcc_pkg::CTRL_EN] || w[dcc_pkg::CTRL_FIN])
                            running_q[ch] = 1'b0;
                        start_ready_channels();
                    end
                end
                dcc_pkg::OP_WRITE32:
                begin
                    if (ch_ok && rg == dcc_pkg::REG_SRC)
                        src_addr_q[ch] = data;
                    else if (ch_ok && rg == dcc_pkg::REG_DST)
                        dst_addr_q[ch] = data;
                end
                dcc_pkg::OP_SET_REQ:
                begin
                    if (line < NUM_LINES)
                        request_q[line] = 1'b1;
                    start_ready_channels();
                end
                dcc_pkg::OP_CLR_REQ:
                begin
                    if (line < NUM_LINES)
                        request_q[line] = 1'b0;
                end
                dcc_pkg::OP_TICK:
                begin
                    // Channels that lost their request pause without finishing.
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        if (running_q[c] && !line_is_set(ctrl_q[c][11:8]))
                            running_q[c] = 1'b0;
                    end
                    // The lowest running channel moves one beat.
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        if (running_q[c] && !moved)
                        begin
                            moved = 1'b1;
                            w = ctrl_q[c];
                            r.move_valid   = 1'b1;
                            r.move_source  = src_addr_q[c];
                            r.move_dest    = dst_addr_q[c];
                            r.move_wide    = w[dcc_pkg::CTRL_WIDE];
                            r.move_channel = c[1:0];
                            src_addr_q[c] = src_addr_q[c] +
                                beat_stride(w[13:12], w[dcc_pkg::CTRL_WIDE]);
                            dst_addr_q[c] = dst_addr_q[c] +
                                beat_stride(w[15:14], w[dcc_pkg::CTRL_WIDE]);
                            count_q[c] = count_q[c] - 17'd1;
                            if (count_q[c] == '0)
                            begin
                                ctrl_q[c][dcc_pkg::CTRL_FIN] = 1'b1;
                                running_q[c] = 1'b0;
                                r.channel_done = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            return r;
        end
    endfunction

    // Send one item, with random gaps before it, and predict its result on acceptance.
    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(input logic [2:0] op, input logic [5:0] off,
                             input logic [31:0] data, input logic [3:0] line);
        begin
            while (gaps_on && ($urandom_range(99) < 32))
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid     <= 1'b1;
            operation    <= op;
            reg_offset   <= off;
            write_data   <= data;
            request_line <= line;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            pending_results.push_back(apply_item(op, off, data, line));
            items_sent++;
            @(negedge clk);
        end
    endtask

    // Hold the sender off until every predicted result has arrived.
    task automatic wait_for_results();
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (want !== got)
            begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                failures++;
            end
        end
    endtask

    // Receiver stalls at random while gaps are enabled.
    always @(negedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(99) < 32);
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item arrived with no prediction waiting");
                failures++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("read_data", 32'(oldest_result.read_data), 32'(read_data));
                check_field("move_valid", 32'(oldest_result.move_valid), 32'(move_valid));
                check_field("move_source", oldest_result.move_source, move_source);
                check_field("move_dest", oldest_result.move_dest, move_dest);
                check_field("move_wide", 32'(oldest_result.move_wide), 32'(move_wide));
                check_field("move_channel", 32'(oldest_result.move_channel),
                            32'(move_channel));
                check_field("channel_done", 32'(oldest_result.channel_done),
                            32'(channel_done));
            end
        end
    end

    // Reset values, unknown offsets, ignored write widths and spare opcodes.
    task automatic test_register_map();
        begin
            send_item(dcc_pkg::OP_READ16, dcc_pkg::OFFS_MASTER, '0, 4'd0);
            send_item(dcc_pkg::OP_READ16, {2'd3, dcc_pkg::REG_CTRL}, '0, 4'd0);
            send_item(dcc_pkg::OP_READ16, {2'd1, dcc_pkg::REG_SRC}, '0, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, {2'd3, dcc_pkg::REG_COUNT}, 32'hFFFF_FFFF, 4'd15);
            send_item(dcc_pkg::OP_READ16, {2'd3, dcc_pkg::REG_COUNT}, '0, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, {2'd2, dcc_pkg::REG_COUNT}, 32'hFFFF_0000, 4'd0);
            send_item(dcc_pkg::OP_READ16, {2'd2, dcc_pkg::REG_COUNT}, '0, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, {2'd0, dcc_pkg::REG_SRC}, 32'h0000_1234, 4'd0);
            send_item(dcc_pkg::OP_WRITE32, {2'd3, dcc_pkg::REG_COUNT}, 32'h0000_0000, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, 6'h3F, 32'hFFFF_FFFF, 4'd0);
            send_item(OP_SPARE6, 6'h3F, 32'hFFFF_FFFF, 4'd15);
            send_item(OP_SPARE7, {2'd0, dcc_pkg::REG_COUNT}, 32'hFFFF_FFFF, 4'd15);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
        end
    endtask

    // Hand-built transfers: wrap, finish, zero-count finish, pause and resume.
    task automatic test_directed_moves();
        begin
            send_item(dcc_pkg::OP_WRITE16, dcc_pkg::OFFS_MASTER, 32'h0000_0001, 4'd0);
            // Channel 0: byte moves on the auto line, source up from the top, dest down.
            send_item(dcc_pkg::OP_WRITE32, {2'd0, dcc_pkg::REG_SRC}, 32'hFFFF_FFFF, 4'd0);
            send_item(dcc_pkg::OP_WRITE32, {2'd0, dcc_pkg::REG_DST}, 32'h0000_0000, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, {2'd0, dcc_pkg::REG_COUNT}, 32'd2, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, {2'd0, dcc_pkg::REG_CTRL},
                      {16'h0, dcc_pkg::STEP_DEC, dcc_pkg::STEP_INC, 4'd0, 8'h01}, 4'd0);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
            // Clearing finished with a zero count finishes again at once.
            send_item(dcc_pkg::OP_WRITE16, {2'd0, dcc_pkg::REG_CTRL},
                      {16'h0, dcc_pkg::STEP_DEC, dcc_pkg::STEP_INC, 4'd0, 8'h01}, 4'd0);
            send_item(dcc_pkg::OP_READ16, {2'd0, dcc_pkg::REG_CTRL}, '0, 4'd0);
            // Channel 1: full 64K wide transfer on line 5, both addresses down.
            send_item(dcc_pkg::OP_WRITE16, {2'd1, dcc_pkg::REG_COUNT}, 32'h0000_0000, 4'd0);
            send_item(dcc_pkg::OP_WRITE16, {2'd1, dcc_pkg::REG_CTRL},
                      {16'h0, dcc_pkg::STEP_DEC, dcc_pkg::STEP_DEC, 4'd5, 8'h09}, 4'd0);
            send_item(dcc_pkg::OP_SET_REQ, '0, '0, 4'd5);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
            // Dropping the request pauses the channel; setting it again resumes.
            send_item(dcc_pkg::OP_CLR_REQ, '0, '0, 4'd5);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
            send_item(dcc_pkg::OP_SET_REQ, '0, '0, 4'd5);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
            send_item(dcc_pkg::OP_READ16, {2'd1, dcc_pkg::REG_COUNT}, '0, 4'd0);
            // Disabling through the control word stops it.
            send_item(dcc_pkg::OP_WRITE16, {2'd1, dcc_pkg::REG_CTRL},
                      {16'hFFFF, STEP_HOLD, STEP_NONE, 4'd5, 8'hF8}, 4'd0);
            send_item(dcc_pkg::OP_TICK, '0, '0, 4'd0);
        end
    endtask

    // Random address that often lands near either end of the space.
    function automatic logic [31:0] pick_address();
        begin
            case ($urandom_range(3))
                0:       return $urandom_range(15);
                1:       return 32'hFFFF_FFFF - $urandom_range(15);
                default: return $urandom;
            endcase
        end
    endfunction

    // Program one channel with random content and mostly short counts.
    task automatic program_channel();
        logic [1:0]  ch;
        logic [15:0] cnt;
        logic [15:0] w;
        begin
            ch = 2'($urandom_range(NUM_CH - 1));
            cnt = ($urandom_range(49) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            w = 16'($urandom);
            w[dcc_pkg::CTRL_EN] = ($urandom_range(9) != 0);
            if ($urandom_range(3) != 0)
                w[11:8] = 4'($urandom_range(3));
            send_item(dcc_pkg::OP_WRITE32, {ch, dcc_pkg::REG_SRC}, pick_address(),
                      4'($urandom));
            send_item(dcc_pkg::OP_WRITE32, {ch, dcc_pkg::REG_DST}, pick_address(),
                      4'($urandom));
            send_item(dcc_pkg::OP_WRITE16, {ch, dcc_pkg::REG_COUNT}, {16'($urandom), cnt},
                      4'($urandom));
            send_item(dcc_pkg::OP_WRITE16, {ch, dcc_pkg::REG_CTRL}, {16'($urandom), w},
                      4'($urandom));
        end
    endtask

    // One random step: mostly ticks and well-formed programming, some noise.
    task automatic random_step();
        int          pick;
        logic [15:0] m;
        begin
            pick = $urandom_range(99);
            m = 16'($urandom);
            m[0] = ($urandom_range(7) != 0);
            if (pick < 45)
                send_item(dcc_pkg::OP_TICK, 6'($urandom), $urandom, 4'($urandom));
            else if (pick < 58)
                program_channel();
            else if (pick < 68)
                send_item(dcc_pkg::OP_SET_REQ, 6'($urandom), $urandom,
                          ($urandom_range(1) != 0) ? 4'($urandom_range(3)) : 4'($urandom));
            else if (pick < 74)
                send_item(dcc_pkg::OP_CLR_REQ, 6'($urandom), $urandom, 4'($urandom));
            else if (pick < 84)
                send_item(dcc_pkg::OP_READ16,
                          {2'($urandom),
                           ($urandom_range(1) != 0) ? dcc_pkg::REG_COUNT : dcc_pkg::REG_CTRL},
                          $urandom, 4'($urandom));
            else if (pick < 89)
                send_item(dcc_pkg::OP_WRITE16, dcc_pkg::OFFS_MASTER, {16'($urandom), m},
                          4'($urandom));
            else
                send_item(3'($urandom), 6'($urandom), $urandom, 4'($urandom));
        end
    endtask

    // Random traffic with gaps, pausing once until every result is in.
    task automatic test_random_traffic();
        begin
            gaps_on = 1'b1;
            while (items_sent < 180)
            begin
                random_step();
            end
            wait_for_results();
            @(negedge clk);
            while (items_sent < 290)
            begin
                random_step();
            end
        end
    endtask

    // A long stretch with neither side idling.
    task automatic test_back_to_back();
        begin
            gaps_on = 1'b0;
            while (items_sent < 400)
            begin
                random_step();
            end
            gaps_on = 1'b1;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = dcc_pkg::OP_READ16;
        reg_offset   = '0;
        write_data   = '0;
        request_line = '0;
        gaps_on      = 1'b1;
        items_sent   = 0;
        failures     = 0;
        clear_channel_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_map();
        test_directed_moves();
        test_random_traffic();
        test_back_to_back();

        wait_for_results();
        repeat (20) @(negedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
